/* hdl/rccn_pkg.sv */
package rccn_pkg;

	localparam int NUM_CHANNELS_DEF = 6;

	localparam int OP_W    = 2;
	localparam int CH_W    = 3;
	localparam int RAW_W   = 16;
	localparam int LEVEL_W = 16;
	localparam int QUO_W   = 14;
	localparam int MAG_W   = QUO_W + 1;

	localparam logic [OP_W-1:0] OP_NORMALIZE    = 2'd0;
	localparam logic [OP_W-1:0] OP_CAL_RANGE    = 2'd1;
	localparam logic [OP_W-1:0] OP_CAL_CENTER   = 2'd2;
	localparam logic [OP_W-1:0] OP_RESET_CAL    = 2'd3;

	localparam logic [RAW_W-1:0] RESET_LEVEL = 16'd1500;
	localparam logic [MAG_W-1:0] FULL_SCALE  = 15'd16384;
	localparam int               SNAP_SHIFT  = 3;

	// one quotient bit per step, quotient stays below full scale
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} rccn_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic step;
		logic load_out;
	} rccn_cmd_t;

	typedef struct packed {
		logic need_div;
	} rccn_sts_t;

endpackage

/* hdl/rccn_if.sv */
interface rccn_item_if import rccn_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [CH_W-1:0]  channel;
	logic [RAW_W-1:0] raw_level;

	modport source(output valid, op, channel, raw_level, input ready);
	modport sink(input valid, op, channel, raw_level, output ready);
endinterface

interface rccn_result_if import rccn_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [LEVEL_W-1:0] level;
	logic                      connected;

	modport source(output valid, level, connected, input ready);
	modport sink(input valid, level, connected, output ready);
endinterface

/* hdl/rccn_dp.sv */
module rccn_dp import rccn_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rccn_cmd_t                 cmd,
	output rccn_sts_t                 sts,
	input  logic [OP_W-1:0]           op,
	input  logic [CH_W-1:0]           channel,
	input  logic [RAW_W-1:0]          raw_level,
	output logic signed [LEVEL_W-1:0] level,
	output logic                      connected
);

	logic [OP_W-1:0]  op_q;
	logic [CH_W-1:0]  ch_q;
	logic [RAW_W-1:0] raw_q;

	logic [RAW_W-1:0] bot_q [NUM_CHANNELS];
	logic [RAW_W-1:0] cen_q [NUM_CHANNELS];
	logic [RAW_W-1:0] top_q [NUM_CHANNELS];

	logic [RAW_W-1:0] rem_q;
	logic [RAW_W-1:0] spn_q;
	logic [QUO_W-1:0] quo_q;
	logic             neg_q;
	logic             sat_q;
	logic             zero_q;

	logic signed [LEVEL_W-1:0] level_q;
	logic                      conn_q;

	logic [RAW_W-1:0]  sel_b, sel_c, sel_t;
	logic              ch_ok;
	logic signed [RAW_W:0] diff, span, diff_abs, span_abs;
	logic [RAW_W-1:0]  diff_mag, span_mag;
	logic              above, below, zero_res, sat_res;
	logic [RAW_W:0]    top_thr, bot_thr;
	logic [RAW_W:0]    rem2;
	logic              qbit;
	logic [MAG_W-1:0]  mag;

	// channel read mux
	always_comb begin
		sel_b = RESET_LEVEL;
		sel_c = RESET_LEVEL;
		sel_t = RESET_LEVEL;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (int'(ch_q) == i) begin
				sel_b = bot_q[i];
				sel_c = cen_q[i];
				sel_t = top_q[i];
			end
		end
	end

	always_comb begin
		ch_ok    = int'(ch_q) < NUM_CHANNELS;
		above    = raw_q > sel_c;
		below    = raw_q < sel_c;
		diff     = signed'({1'b0, raw_q}) - signed'({1'b0, sel_c});
		span     = above ? signed'({1'b0, sel_t}) - signed'({1'b0, sel_c})
		                 : signed'({1'b0, sel_c}) - signed'({1'b0, sel_b});
		diff_abs = diff[RAW_W] ? -diff : diff;
		span_abs = span[RAW_W] ? -span : span;
		diff_mag = diff_abs[RAW_W-1:0];
		span_mag = span_abs[RAW_W-1:0];
		zero_res = (op_q != OP_NORMALIZE) || !ch_ok || (raw_q == '0) ||
		           (diff == '0) || (span == '0);
		// |diff| >= |span| means the quotient reaches full scale
		sat_res  = diff_mag >= span_mag;
		sts.need_div = !zero_res && !sat_res;
		top_thr  = {1'b0, sel_t} - {1'b0, (sel_t >> SNAP_SHIFT)};
		bot_thr  = {1'b0, sel_b} + {1'b0, (sel_b >> SNAP_SHIFT)};
	end

	// restoring divide step
	always_comb begin
		rem2 = {rem_q, 1'b0};
		qbit = rem2 >= {1'b0, spn_q};
	end

	always_comb begin
		if (zero_q) begin
			mag = '0;
		end else if (sat_q) begin
			mag = FULL_SCALE;
		end else begin
			mag = {1'b0, quo_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			ch_q  <= channel;
			raw_q <= raw_level;
		end
		if (cmd.exec) begin
			rem_q  <= diff_mag;
			spn_q  <= span_mag;
			quo_q  <= '0;
			neg_q  <= below ^ span[RAW_W];
			sat_q  <= sat_res;
			zero_q <= zero_res;
		end else if (cmd.step) begin
			if (qbit) begin
				rem_q <= RAW_W'(rem2 - {1'b0, spn_q});
			end else begin
				rem_q <= rem2[RAW_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
		if (cmd.load_out) begin
			level_q <= neg_q ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
			conn_q  <= raw_q != '0;
		end
	end

	// calibration tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				bot_q[i] <= RESET_LEVEL;
				cen_q[i] <= RESET_LEVEL;
				top_q[i] <= RESET_LEVEL;
			end
		end else if (cmd.exec) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (op_q == OP_RESET_CAL) begin
					bot_q[i] <= RESET_LEVEL;
					cen_q[i] <= RESET_LEVEL;
					top_q[i] <= RESET_LEVEL;
				end else if (int'(ch_q) == i) begin
					if (op_q == OP_CAL_RANGE) begin
						if (raw_q > top_q[i]) begin
							top_q[i] <= raw_q;
						end
						if (raw_q < bot_q[i]) begin
							bot_q[i] <= raw_q;
						end
					end else if (op_q == OP_CAL_CENTER) begin
						if ({1'b0, raw_q} > top_thr) begin
							cen_q[i] <= top_q[i];
						end else if ({1'b0, raw_q} < bot_thr) begin
							cen_q[i] <= bot_q[i];
						end else begin
							cen_q[i] <= raw_q;
						end
					end
				end
			end
		end
	end

	assign level     = level_q;
	assign connected = conn_q;

endmodule

/* hdl/rccn_ctrl.sv */
module rccn_ctrl import rccn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output rccn_cmd_t cmd,
	input  rccn_sts_t sts
);

	rccn_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cmd.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_div ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_EXEC)
		else $error("accepted request not executed");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && sts.need_div) |=> (state_q == ST_DIV && cnt_q != '0))
		else $error("divider not started");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_busy_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_DONE) |-> !in_ready)
		else $error("request taken while busy");

endmodule

/* hdl/rc_channel_calibrate_normalize_top.sv */
// rc channel calibration and normalization
//
// item channel (sink): op, channel, raw_level. one request is taken when
// valid and ready are both high. result channel (source): level (signed
// q2.14, 16384 is full scale) and connected, one result per request.
// normalize maps raw_level against the channel's bottom/center/top levels;
// calibrate range widens top or bottom, calibrate center sets the center with
// snapping to an endpoint within one eighth, reset sets every level to 1500.
// calibration ops and normalize with a trivial answer (no signal, at center,
// zero span, or saturated) skip the divider; otherwise the 14-step restoring
// divider runs before the result is loaded.
// one request is in flight at a time; a new request is taken only once the
// previous one has been loaded into the result register.
// the result register is separate, so the next request is taken while a
// result still waits; a stalled receiver holds the result and the block
// waits before loading the next one.
// asynchronous reset puts every calibration level to 1500 and empties the
// result register.
module rc_channel_calibrate_normalize_top import rccn_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rccn_item_if.sink     item,
	rccn_result_if.source result
);

	rccn_cmd_t cmd;
	rccn_sts_t sts;

	// sequencer: accept, execute, divide, hand off
	rccn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// calibration tables, divider and result register
	rccn_dp #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.op        (item.op),
		.channel   (item.channel),
		.raw_level (item.raw_level),
		.level     (result.level),
		.connected (result.connected)
	);

endmodule

/* tb/sv/rc_channel_calibrate_normalize_top_test.sv */
module rc_channel_calibrate_normalize_top_test;
	import rccn_pkg::*;

	localparam int NUM_CH         = NUM_CHANNELS_DEF;
	// longest path through the block is the divider loop
	localparam int LATENCY_MAX    = 17;
	localparam int STALL_MAX      = 12;
	localparam int HOLDOFF_CYCLES = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAW_MAX        = (1 << RAW_W) - 1;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic                      connected;
	} stick_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rccn_item_if   item_if();
	rccn_result_if result_if();

	rc_channel_calibrate_normalize_top #(
		.NUM_CHANNELS(NUM_CH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_if),
		.result(result_if)
	);

	// shadow calibration per channel, updated as each request is accepted
	logic [RAW_W-1:0] cal_bottom [NUM_CH];
	logic [RAW_W-1:0] cal_center [NUM_CH];
	logic [RAW_W-1:0] cal_top    [NUM_CH];

	// predicted results in request order
	stick_result_t pending_results[$];

	int error_count = 0;
	bit send_gaps;
	bit recv_gaps;
	// count of long hold-offs asked of the receiver
	int hold_request;
	int idle_cycles = 0;

	always #4 clk = ~clk;

	function automatic void reset_calibration();
		for (int i = 0; i < NUM_CH; i++) begin
			cal_bottom[i] = RESET_LEVEL;
			cal_center[i] = RESET_LEVEL;
			cal_top[i]    = RESET_LEVEL;
		end
	endfunction

	// q2.14 stick position: (raw - center) * 16384 / span, truncated and clamped
	function automatic logic signed [LEVEL_W-1:0] stick_position(int ch, int raw);
		int     ctr;
		int     diff;
		int     span;
		longint quo;
		ctr  = cal_center[ch];
		diff = raw - ctr;
		if (raw == 0 || diff == 0)
			return '0;
		// upper half spans to top, lower half to bottom
		span = (diff > 0) ? int'(cal_top[ch]) - ctr : ctr - int'(cal_bottom[ch]);
		if (span == 0)
			return '0;
		quo = (longint'(diff) * longint'(FULL_SCALE)) / span;
		if (quo > longint'(FULL_SCALE))
			quo = longint'(FULL_SCALE);
		if (quo < -longint'(FULL_SCALE))
			quo = -longint'(FULL_SCALE);
		return quo[LEVEL_W-1:0];
	endfunction

	function automatic stick_result_t predict_request(logic [OP_W-1:0] op,
			logic [CH_W-1:0] ch, logic [RAW_W-1:0] raw);
		stick_result_t res;
		bit            in_range;
		int            top_thr;
		int            bot_thr;
		in_range      = (ch < NUM_CH);
		res.level     = '0;
		res.connected = (raw != '0);
		case (op)
			OP_NORMALIZE: begin
				if (in_range)
					res.level = stick_position(int'(ch), int'(raw));
			end
			OP_CAL_RANGE: begin
				if (in_range) begin
					if (raw > cal_top[ch])
						cal_top[ch] = raw;
					if (raw < cal_bottom[ch])
						cal_bottom[ch] = raw;
				end
			end
			OP_CAL_CENTER: begin
				if (in_range) begin
					// snap window is one eighth of the endpoint, top checked first
					top_thr = int'(cal_top[ch]) - int'(cal_top[ch] >> SNAP_SHIFT);
					bot_thr = int'(cal_bottom[ch]) + int'(cal_bottom[ch] >> SNAP_SHIFT);
					if (int'(raw) > top_thr)
						cal_center[ch] = cal_top[ch];
					else if (int'(raw) < bot_thr)
						cal_center[ch] = cal_bottom[ch];
					else
						cal_center[ch] = raw;
				end
			end
			OP_RESET_CAL: begin
				reset_calibration();
			end
			default: ;
		endcase
		return res;
	endfunction

	// raw levels biased toward the interesting spots of the channel's calibration
	function automatic logic [RAW_W-1:0] draw_raw(logic [CH_W-1:0] ch);
		int v;
		int pick;
		v    = $urandom;
		pick = $urandom_range(0, 9);
		if (ch < NUM_CH) begin
			case (pick)
				0: v = 0;
				1: v = $urandom;
				2: v = int'(cal_top[ch]) + $urandom_range(0, 16) - 8;
				3: v = int'(cal_bottom[ch]) + $urandom_range(0, 16) - 8;
				4: v = int'(cal_center[ch]) + $urandom_range(0, 6) - 3;
				5: v = int'(cal_top[ch]) - int'(cal_top[ch] >> SNAP_SHIFT)
					+ $urandom_range(0, 4) - 2;
				6: v = int'(cal_bottom[ch]) + int'(cal_bottom[ch] >> SNAP_SHIFT)
					+ $urandom_range(0, 4) - 2;
				default: v = $urandom_range(700, 2300);
			endcase
			if (v < 0)
				v = 0;
			if (v > RAW_MAX)
				v = RAW_MAX;
		end
		return v[RAW_W-1:0];
	endfunction

	// one request: optional gap, then hold valid until the block takes it
	task automatic send_request(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
			input logic [RAW_W-1:0] raw);
		int gap;
		gap = send_gaps ? $urandom_range(0, STALL_MAX) : 0;
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid     <= 1'b1;
		item_if.op        <= op;
		item_if.channel   <= ch;
		item_if.raw_level <= raw;
		do @(posedge clk); while (!item_if.ready);
		pending_results.push_back(predict_request(op, ch, raw));
	endtask

	// stop offering requests and let every outstanding result come back
	task automatic wait_drained();
		item_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY_MAX + 3) @(posedge clk);
	endtask

	task automatic test_directed();
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		// fresh calibration has zero spans everywhere
		send_request(OP_NORMALIZE, 3'd0, 16'd1500);
		send_request(OP_NORMALIZE, 3'd0, 16'd2000);
		send_request(OP_NORMALIZE, 3'd0, 16'd1000);
		send_request(OP_NORMALIZE, 3'd0, 16'd0);
		// open up channel 0 to 1000..2000
		send_request(OP_CAL_RANGE, 3'd0, 16'd1000);
		send_request(OP_CAL_RANGE, 3'd0, 16'd2000);
		send_request(OP_NORMALIZE, 3'd0, 16'd2000);
		send_request(OP_NORMALIZE, 3'd0, 16'd1750);
		send_request(OP_NORMALIZE, 3'd0, 16'd1250);
		// far outside the range saturates both ways
		send_request(OP_NORMALIZE, 3'd0, 16'hFFFF);
		send_request(OP_NORMALIZE, 3'd0, 16'd1);
		// center near top snaps to top, leaving a zero upper span
		send_request(OP_CAL_CENTER, 3'd0, 16'd1900);
		send_request(OP_NORMALIZE, 3'd0, 16'd2100);
		// center near bottom snaps to bottom, then a plain center
		send_request(OP_CAL_CENTER, 3'd0, 16'd1050);
		send_request(OP_CAL_CENTER, 3'd0, 16'd1400);
		send_request(OP_NORMALIZE, 3'd0, 16'd1401);
		// range with no signal drops bottom to 0
		send_request(OP_CAL_RANGE, 3'd2, 16'd0);
		send_request(OP_NORMALIZE, 3'd2, 16'd1);
		// full-width top
		send_request(OP_CAL_RANGE, 3'd3, 16'hFFFF);
		send_request(OP_NORMALIZE, 3'd3, 16'h8000);
		// channels past the last one touch nothing
		send_request(OP_NORMALIZE, 3'd6, 16'hFFFF);
		send_request(OP_CAL_RANGE, 3'd7, 16'd40000);
		send_request(OP_CAL_CENTER, 3'd6, 16'd3000);
		send_request(OP_NORMALIZE, 3'd7, 16'd0);
		// reset ignores the channel field
		send_request(OP_RESET_CAL, 3'd7, 16'd0);
		send_request(OP_NORMALIZE, 3'd0, 16'd2000);
	endtask

	// receiver stalls long enough that the block backs up into the request side
	task automatic test_receiver_holdoff();
		logic [CH_W-1:0] ch;
		send_gaps    = 1'b0;
		recv_gaps    = 1'b0;
		hold_request = hold_request + 1;
		for (int i = 0; i < 30; i++) begin
			ch = CH_W'($urandom_range(0, NUM_CH - 1));
			send_request(i % 4 == 3 ? OP_CAL_RANGE : OP_NORMALIZE, ch, draw_raw(ch));
		end
	endtask

	// typical setup flow: sweep the stick, set center, then move it around
	task automatic test_calibration_sessions(input int count);
		logic [CH_W-1:0] ch;
		for (int s = 0; s < count; s++) begin
			send_gaps = ($urandom_range(0, 3) != 0);
			recv_gaps = ($urandom_range(0, 3) != 0);
			ch = CH_W'($urandom_range(0, NUM_CH - 1));
			if ($urandom_range(0, 3) == 0)
				send_request(OP_RESET_CAL, CH_W'($urandom_range(0, 7)), RAW_W'($urandom));
			send_request(OP_CAL_RANGE, ch, RAW_W'($urandom_range(800, 1400)));
			send_request(OP_CAL_RANGE, ch, RAW_W'($urandom_range(1600, 2200)));
			send_request(OP_CAL_RANGE, ch, RAW_W'($urandom_range(900, 2100)));
			send_request(OP_CAL_CENTER, ch,
				$urandom_range(0, 2) == 0 ? draw_raw(ch)
					: RAW_W'($urandom_range(1300, 1700)));
			for (int i = 0; i < 8; i++)
				send_request(OP_NORMALIZE, ch, draw_raw(ch));
		end
	endtask

	// loose mix of all operations, mostly valid channels
	task automatic test_random_mix(input int count);
		logic [OP_W-1:0] op;
		logic [CH_W-1:0] ch;
		int              sel;
		for (int i = 0; i < count; i++) begin
			// switch idling on and off in stretches
			if (i % 50 == 0) begin
				send_gaps = ($urandom_range(0, 3) != 0);
				recv_gaps = ($urandom_range(0, 3) != 0);
			end
			sel = $urandom_range(0, 99);
			if (sel < 60)
				op = OP_NORMALIZE;
			else if (sel < 80)
				op = OP_CAL_RANGE;
			else if (sel < 99)
				op = OP_CAL_CENTER;
			else
				op = OP_RESET_CAL;
			if ($urandom_range(0, 19) == 0)
				ch = CH_W'($urandom_range(NUM_CH, 7));
			else
				ch = CH_W'($urandom_range(0, NUM_CH - 1));
			send_request(op, ch, draw_raw(ch));
		end
	endtask

	// result side: random stalls, then compare against the oldest prediction
	initial begin
		int            stall;
		int            holds_done;
		stick_result_t want;
		holds_done = 0;
		result_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_request != holds_done) begin
				stall      = HOLDOFF_CYCLES;
				holds_done = holds_done + 1;
			end else begin
				stall = recv_gaps ? $urandom_range(0, STALL_MAX) : 0;
			end
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			if (pending_results.size() == 0) begin
				$error("unexpected result: level %0d, connected %0b",
					$signed(result_if.level), result_if.connected);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_if.level !== want.level) begin
					$error("level: expected %0d, actual %0d",
						$signed(want.level), $signed(result_if.level));
					error_count++;
				end
				if (result_if.connected !== want.connected) begin
					$error("connected: expected %0b, actual %0b",
						want.connected, result_if.connected);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		item_if.valid     <= 1'b0;
		item_if.op        <= OP_NORMALIZE;
		item_if.channel   <= '0;
		item_if.raw_level <= '0;
		hold_request       = 0;
		send_gaps          = 1'b1;
		recv_gaps          = 1'b1;
		reset_calibration();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		test_receiver_holdoff();
		wait_drained();
		test_calibration_sessions(25);
		wait_drained();
		test_random_mix(450);
		wait_drained();

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* rc_channel_calibrate_normalize_top.f */
hdl/rccn_pkg.sv
hdl/rccn_if.sv
hdl/rccn_dp.sv
hdl/rccn_ctrl.sv
hdl/rc_channel_calibrate_normalize_top.sv
tb/sv/rc_channel_calibrate_normalize_top_test.sv
